// ----- hw/rtl/cwbc_pkg.sv -----
// Shared types, constants and lookup tables for the channel watchdog blink code block.
// Used by the channel interfaces, the datapath, the controller and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cwbc_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_CHANNELS_DEF = 11;
  localparam int COUNT_WIDTH_DEF  = 12;

  // Fixed field and register widths
  localparam int CHANNEL_W   = 4;
  localparam int TPS_W       = 10;
  localparam int ERR_OUT_W   = 11;
  localparam int SHOWN_OUT_W = 4;
  localparam int TIME_W      = 32;   // span and flash tick counters, divider dividend
  localparam int DVSR_W      = 16;   // widest divisor: tick rate or flash period
  localparam int PROD_W      = 13;   // tick rate times on-window seconds

  localparam logic [TPS_W-1:0] TPS_RESET   = 10'd250;
  localparam int               COUNT_RESET = 2000;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_FEED = 1'b1
  } cwbc_func_e;

  typedef enum logic [1:0] {
    DIV_SEC    = 2'd0,   // span ticks / tick rate
    DIV_POS    = 2'd1,   // seconds mod cycle length
    DIV_PERIOD = 2'd2,   // tick rate * window / (2 * flashes)
    DIV_PHASE  = 2'd3    // flash ticks mod flash period
  } cwbc_div_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FEED,
    ST_SWEEP,
    ST_SEC_GO,
    ST_POS_GO,
    ST_PERIOD_GO,
    ST_PHASE_GO,
    ST_DIV_WAIT,
    ST_WINDOW,
    ST_TOGGLE,
    ST_DONE
  } cwbc_state_e;

  typedef struct packed {
    logic       green;
    logic [2:0] cycle;
    logic [2:0] window;
    logic [3:0] flashes;
  } cwbc_pat_t;

  typedef struct packed {
    logic         in_take;
    logic         feed;
    logic         sweep;
    logic         div_start;
    cwbc_div_op_e div_op;
    logic         flash_inc;
    logic         flash_clr;
    logic         led_off;
    logic         led_steady;
    logic         led_flip;
    logic         out_load;
  } cwbc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic win_zero;
    logic in_window;
    logic steady;
    logic phase_zero;
  } cwbc_sts_t;

  localparam cwbc_pat_t HEALTHY_PAT = '{green: 1'b1, cycle: 3'd6, window: 3'd6, flashes: 4'd0};

  // Timeout limit of each channel: calibration channel first
  function automatic logic [8:0] chan_limit(input logic [CHANNEL_W-1:0] idx);
    logic [8:0] lim;
    case (idx)
      4'd0:    lim = 9'd20;
      4'd1:    lim = 9'd200;
      4'd10:   lim = 9'd100;
      default: lim = 9'd500;
    endcase
    return lim;
  endfunction

  // Blink pattern shown for each timed-out channel
  function automatic cwbc_pat_t chan_pat(input logic [CHANNEL_W-1:0] idx);
    cwbc_pat_t p;
    case (idx)
      4'd0:    p = '{green: 1'b0, cycle: 3'd6, window: 3'd0, flashes: 4'd0};
      4'd1:    p = '{green: 1'b0, cycle: 3'd6, window: 3'd0, flashes: 4'd1};
      4'd2:    p = '{green: 1'b0, cycle: 3'd7, window: 3'd5, flashes: 4'd10};
      4'd3:    p = '{green: 1'b0, cycle: 3'd5, window: 3'd3, flashes: 4'd6};
      4'd4:    p = '{green: 1'b0, cycle: 3'd5, window: 3'd3, flashes: 4'd5};
      4'd5:    p = '{green: 1'b0, cycle: 3'd3, window: 3'd2, flashes: 4'd1};
      4'd6:    p = '{green: 1'b0, cycle: 3'd4, window: 3'd2, flashes: 4'd2};
      4'd7:    p = '{green: 1'b0, cycle: 3'd5, window: 3'd3, flashes: 4'd3};
      4'd8:    p = '{green: 1'b0, cycle: 3'd5, window: 3'd3, flashes: 4'd4};
      4'd9:    p = '{green: 1'b1, cycle: 3'd5, window: 3'd5, flashes: 4'd5};
      default: p = '{green: 1'b0, cycle: 3'd6, window: 3'd6, flashes: 4'd6};
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cwbc_in_if.sv -----
// Input channel of the watchdog block: valid/ready handshake with the item fields.
// Depends on cwbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cwbc_in_if;
  import cwbc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [CHANNEL_W-1:0] channel;
  logic                 calibrated;

  modport source (output valid, func, channel, calibrated, input ready);
  modport sink   (input valid, func, channel, calibrated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cwbc_out_if.sv -----
// Result channel of the watchdog block: valid/ready handshake with the LED and error fields.
// Depends on cwbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cwbc_out_if;
  import cwbc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   red_led;
  logic                   green_led;
  logic [ERR_OUT_W-1:0]   error_mask;
  logic [SHOWN_OUT_W-1:0] shown_error;

  modport source (output valid, red_led, green_led, error_mask, shown_error, input ready);
  modport sink   (input valid, red_led, green_led, error_mask, shown_error, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cwbc_div.sv -----
// Shared restoring divider, one quotient bit per cycle; results hold until the next start.
// Standalone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module cwbc_div #(
  parameter int DVD_W  = 32,
  parameter int DVSR_W = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DVD_W-1:0]  dividend_i,
  input  wire logic [DVSR_W-1:0] divisor_i,
  output      logic              done_o,
  output      logic [DVD_W-1:0]  quot_o,
  output      logic [DVSR_W-1:0] rem_o
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVSR_W-1:0] rem_q;
  logic [DVSR_W-1:0] dvsr_q;

  logic [DVSR_W:0]   trial;
  logic              ge;
  logic [DVSR_W-1:0] rem_d;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    ge    = (trial >= {1'b0, dvsr_q});
    rem_d = ge ? DVSR_W'(trial - {1'b0, dvsr_q}) : trial[DVSR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = busy_q && (cnt_q == LAST);
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cwbc_dp.sv -----
// Datapath: channel counters, error bits, blink timing, LED state and the result register.
// Depends on cwbc_pkg and cwbc_div.
`timescale 1ns / 1ps
`default_nettype none

module cwbc_dp #(
  parameter int NUM_CHANNELS = cwbc_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = cwbc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [cwbc_pkg::TPS_W-1:0]         cfg_wdata_i,
  input  wire logic [cwbc_pkg::CHANNEL_W-1:0]     in_channel_i,
  input  wire logic                               in_calibrated_i,
  input  wire cwbc_pkg::cwbc_cmd_t                cmd_i,
  output      cwbc_pkg::cwbc_sts_t                sts_o,
  output      logic                               red_led_o,
  output      logic                               green_led_o,
  output      logic [cwbc_pkg::ERR_OUT_W-1:0]     error_mask_o,
  output      logic [cwbc_pkg::SHOWN_OUT_W-1:0]   shown_error_o
);
  import cwbc_pkg::*;

  localparam int SHOWN_W = $clog2(NUM_CHANNELS + 1);
  localparam logic [SHOWN_W-1:0] HEALTHY_IDX = SHOWN_W'(NUM_CHANNELS);

  logic [TPS_W-1:0]       tps_q;
  logic [CHANNEL_W-1:0]   chan_q;
  logic                   cal_q;
  logic [COUNT_WIDTH-1:0] cnt_q [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] cnt_d [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] err_q, err_d;
  logic [TIME_W-1:0]      span_q, flash_q;
  logic                   red_q, green_q;
  logic                   red_d, green_d;

  logic [TPS_W-1:0]       tps_eff;
  logic [SHOWN_W-1:0]     shown;
  cwbc_pat_t              pat;
  logic [PROD_W-1:0]      prod;
  logic [DVSR_W-1:0]      period;

  logic                   div_done;
  logic [TIME_W-1:0]      div_quot;
  logic [DVSR_W-1:0]      div_rem;
  logic [TIME_W-1:0]      div_dvd;
  logic [DVSR_W-1:0]      div_dvsr;

  assign tps_eff = (tps_q == '0) ? TPS_W'(1) : tps_q;

  // Lowest-numbered timed-out channel wins
  always_comb begin
    shown = HEALTHY_IDX;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (err_q[i]) begin
        shown = SHOWN_W'(i);
      end
    end
  end

  assign pat    = (shown == HEALTHY_IDX) ? HEALTHY_PAT : chan_pat(CHANNEL_W'(shown));
  assign prod   = PROD_W'(tps_eff) * PROD_W'(pat.window);
  assign period = (div_quot == '0) ? DVSR_W'(1) : div_quot[DVSR_W-1:0];

  // Divider operand select
  always_comb begin
    case (cmd_i.div_op)
      DIV_SEC: begin
        div_dvd  = span_q;
        div_dvsr = DVSR_W'(tps_eff);
      end
      DIV_POS: begin
        div_dvd  = div_quot;
        div_dvsr = DVSR_W'(pat.cycle);
      end
      DIV_PERIOD: begin
        div_dvd  = TIME_W'(prod);
        div_dvsr = DVSR_W'({pat.flashes, 1'b0});
      end
      DIV_PHASE: begin
        div_dvd  = flash_q;
        div_dvsr = period;
      end
      default: begin
        div_dvd  = span_q;
        div_dvsr = DVSR_W'(tps_eff);
      end
    endcase
  end

  cwbc_div #(
    .DVD_W  (TIME_W),
    .DVSR_W (DVSR_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Feed clears one counter; a sweep advances every channel against its limit
  always_comb begin
    logic [COUNT_WIDTH-1:0] cur;
    err_d = err_q;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      cnt_d[i] = cnt_q[i];
      cur      = cnt_q[i];
      if (cmd_i.feed && (chan_q == CHANNEL_W'(i))) begin
        cnt_d[i] = '0;
      end
      if (cmd_i.sweep) begin
        if ((i == 0) && cal_q) begin
          cur = '0;
        end
        if (cur > COUNT_WIDTH'(chan_limit(CHANNEL_W'(i)))) begin
          cnt_d[i] = cur;
          err_d[i] = 1'b1;
        end else begin
          cnt_d[i] = cur + COUNT_WIDTH'(1);
          err_d[i] = 1'b0;
        end
      end
    end
  end

  // LED drive updates
  always_comb begin
    red_d   = red_q;
    green_d = green_q;
    if (cmd_i.led_off) begin
      red_d   = 1'b0;
      green_d = 1'b0;
    end else if (cmd_i.led_steady) begin
      red_d   = !pat.green;
      green_d = pat.green;
    end else if (cmd_i.led_flip) begin
      if (pat.green) begin
        green_d = !green_q;
        red_d   = 1'b0;
      end else begin
        red_d   = !red_q;
        green_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q   <= TPS_RESET;
      err_q   <= '1;
      span_q  <= '0;
      flash_q <= '0;
      red_q   <= 1'b0;
      green_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cnt_q[i] <= COUNT_WIDTH'(COUNT_RESET);
      end
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      err_q <= err_d;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
      if (cmd_i.sweep) begin
        span_q <= span_q + TIME_W'(1);
      end
      if (cmd_i.flash_clr) begin
        flash_q <= '0;
      end else if (cmd_i.flash_inc) begin
        flash_q <= flash_q + TIME_W'(1);
      end
      red_q   <= red_d;
      green_q <= green_d;
    end
  end

  // Latch the item and the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      chan_q <= in_channel_i;
      cal_q  <= in_calibrated_i;
    end
    if (cmd_i.out_load) begin
      red_led_o     <= red_q;
      green_led_o   <= green_q;
      error_mask_o  <= ERR_OUT_W'(err_q);
      shown_error_o <= SHOWN_OUT_W'(shown);
    end
  end

  always_comb begin
    sts_o.div_done   = div_done;
    sts_o.win_zero   = (pat.window == '0);
    sts_o.in_window  = (pat.window == '0) || (div_rem < DVSR_W'(pat.window));
    sts_o.steady     = (pat.window == '0) || (pat.flashes == '0);
    sts_o.phase_zero = (div_rem == '0);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cwbc_ctrl.sv -----
// Controller: sequences feed, counter sweep and the blink-timing divisions; owns result valid.
// Depends on cwbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwbc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_func_i,
  output      logic                 in_ready_o,
  input  wire logic                 out_ready_i,
  output      logic                 out_valid_o,
  input  wire cwbc_pkg::cwbc_sts_t  sts_i,
  output      cwbc_pkg::cwbc_cmd_t  cmd_o
);
  import cwbc_pkg::*;

  cwbc_state_e  state_q, state_d;
  cwbc_div_op_e op_q, op_d;
  logic         out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= DIV_SEC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    cmd_o        = '0;
    cmd_o.div_op = op_q;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_take = 1'b1;
          state_d = (cwbc_func_e'(in_func_i) == FUNC_FEED) ? ST_FEED : ST_SWEEP;
        end
      end
      ST_FEED: begin
        cmd_o.feed = 1'b1;
        state_d    = ST_DONE;
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        state_d     = ST_SEC_GO;
      end
      ST_SEC_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_SEC;
        op_d            = DIV_SEC;
        state_d         = ST_DIV_WAIT;
      end
      ST_POS_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_POS;
        op_d            = DIV_POS;
        state_d         = ST_DIV_WAIT;
      end
      ST_PERIOD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_PERIOD;
        op_d            = DIV_PERIOD;
        state_d         = ST_DIV_WAIT;
      end
      ST_PHASE_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_PHASE;
        op_d            = DIV_PHASE;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          case (op_q)
            DIV_SEC:    state_d = sts_i.win_zero ? ST_WINDOW : ST_POS_GO;
            DIV_POS:    state_d = ST_WINDOW;
            DIV_PERIOD: state_d = ST_PHASE_GO;
            DIV_PHASE:  state_d = ST_TOGGLE;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_WINDOW: begin
        if (!sts_i.in_window) begin
          cmd_o.flash_clr = 1'b1;
          cmd_o.led_off   = 1'b1;
          state_d         = ST_DONE;
        end else begin
          cmd_o.flash_inc = 1'b1;
          if (sts_i.steady) begin
            cmd_o.led_steady = 1'b1;
            state_d          = ST_DONE;
          end else begin
            state_d = ST_PERIOD_GO;
          end
        end
      end
      ST_TOGGLE: begin
        cmd_o.led_flip = sts_i.phase_zero;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/channel_watchdog_blink_code_core.sv -----
// Top level of the channel watchdog blink code block: controller, datapath and channel ports.
// Depends on cwbc_pkg, cwbc_in_if, cwbc_out_if, cwbc_ctrl and cwbc_dp.
`timescale 1ns / 1ps
`default_nettype none

// Bank of per-channel lost-signal watchdogs driving a red/green LED blink code. Each input
// transaction is either a feed (clear one channel's counter) or a supervision tick (optionally
// feed the calibration channel, advance every counter against its fixed limit, update the
// error bits, then step the blink pattern of the highest-priority timed-out channel, or the
// healthy pattern). Every input transaction yields exactly one result transaction carrying the
// LED drive, the error mask and the channel being shown. One transaction is worked on at a
// time; a finished result sits in the output register, so the next input transaction can be
// taken while that result waits. A tick whose pattern has no on-window needs only the seconds
// division; otherwise the blink timing needs up to four divisions (seconds, position in the cycle,
// flash period, flash phase), each run on one shared restoring divider that produces one quotient
// bit per cycle. ticks_per_second must be written through cfg_we_i/cfg_wdata_i only while the
// block is idle; the block itself does not enforce this. A value of zero behaves as one.
module channel_watchdog_blink_code_core #(
  parameter int NUM_CHANNELS = cwbc_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = cwbc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [cwbc_pkg::TPS_W-1:0] cfg_wdata_i,
  cwbc_in_if.sink                         in_i,
  cwbc_out_if.source                      out_o
);
  import cwbc_pkg::*;

  cwbc_cmd_t cmd;
  cwbc_sts_t sts;

  // Sequencing: handshakes, division launches, LED update commands
  cwbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Counters, error bits, blink timing and the result payload register
  cwbc_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_channel_i    (in_i.channel),
    .in_calibrated_i (in_i.calibrated),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .red_led_o       (out_o.red_led),
    .green_led_o     (out_o.green_led),
    .error_mask_o    (out_o.error_mask),
    .shown_error_o   (out_o.shown_error)
  );

`ifndef ASSERT_OFF
  // Taking an input transaction must close the input until its work is done
  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input stayed ready after accepting a transaction");

  // Never overwrite a result that has not been taken
  a_load_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("result register loaded while occupied");

  // A new result appears only from a load of the result register
  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.out_load))
    else $error("result valid rose without a load");

  // The divider must not report done straight after a launch
  a_div_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !sts.div_done)
    else $error("division finished right after launch");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for channel_watchdog_blink_code_core: feeds and supervision ticks
// go in over the input channel, each result is checked against a predictor kept in the bench.
// Depends on cwbc_pkg, cwbc_in_if, cwbc_out_if and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import cwbc_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;

  // Blink pattern of one shown channel, kept at 32 bits for the timing arithmetic
  typedef struct {
    bit          green;
    int unsigned cycle;
    int unsigned window;
    int unsigned flashes;
  } blink_pat_t;

  // One result transaction as the block should report it
  typedef struct packed {
    logic                   red;
    logic                   green;
    logic [ERR_OUT_W-1:0]   errors;
    logic [SHOWN_OUT_W-1:0] shown;
  } led_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [TPS_W-1:0] cfg_wdata_i;

  cwbc_in_if  in_ch ();
  cwbc_out_if out_ch ();

  channel_watchdog_blink_code_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: a private copy of everything the block remembers
  logic [COUNT_WIDTH_DEF-1:0] lost_cnt [NCH];
  logic [NCH-1:0]             err_bits;
  logic [31:0]                span_cnt;
  logic [31:0]                flash_cnt;
  logic                       red_q;
  logic                       green_q;
  logic [TPS_W-1:0]           tick_rate;

  led_result_t expected_leds [$];

  // Traffic shaping, in percent, and the long receiver hold-off counted in cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;

  int items_sent      = 0;
  int results_checked = 0;
  int error_count     = 0;

  // Timeout threshold of each watchdog channel
  function automatic int unsigned timeout_limit(input int ch);
    case (ch)
      0:       return 20;
      1:       return 200;
      10:      return 100;
      default: return 500;
    endcase
  endfunction

  // Pattern shown while a channel is the highest-priority timed-out one
  function automatic blink_pat_t blink_pattern(input int ch);
    case (ch)
      0:       return '{1'b0, 6, 0, 0};
      1:       return '{1'b0, 6, 0, 1};
      2:       return '{1'b0, 7, 5, 10};
      3:       return '{1'b0, 5, 3, 6};
      4:       return '{1'b0, 5, 3, 5};
      5:       return '{1'b0, 3, 2, 1};
      6:       return '{1'b0, 4, 2, 2};
      7:       return '{1'b0, 5, 3, 3};
      8:       return '{1'b0, 5, 3, 4};
      9:       return '{1'b1, 5, 5, 5};
      default: return '{1'b0, 6, 6, 6};
    endcase
  endfunction

  function automatic int first_error();
    int s;
    s = NCH;
    for (int i = NCH - 1; i >= 0; i--) begin
      if (err_bits[i]) s = i;
    end
    return s;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < NCH; i++) lost_cnt[i] = COUNT_WIDTH_DEF'(COUNT_RESET);
    err_bits  = '1;
    span_cnt  = '0;
    flash_cnt = '0;
    red_q     = 1'b0;
    green_q   = 1'b0;
    tick_rate = TPS_RESET;
  endtask

  // Advance the LED pattern by one tick
  function automatic void advance_blink(input blink_pat_t p);
    logic [31:0] rate;
    logic [31:0] sec;
    logic [31:0] pos;
    logic [31:0] period;
    rate     = (tick_rate == '0) ? 32'd1 : 32'(tick_rate);
    span_cnt = span_cnt + 32'd1;
    sec      = span_cnt / rate;
    pos      = sec % p.cycle;
    if (p.window == 0 || pos < p.window) begin
      flash_cnt = flash_cnt + 32'd1;
      if (p.window == 0 || p.flashes == 0) begin
        // Steady light of the pattern color; a zero window means steady red
        red_q   = !p.green;
        green_q = p.green;
      end else begin
        period = (rate * p.window) / (2 * p.flashes);
        if (period == 0) period = 32'd1;
        if (flash_cnt % period == 0) begin
          if (p.green) begin
            green_q = !green_q;
            red_q   = 1'b0;
          end else begin
            red_q   = !red_q;
            green_q = 1'b0;
          end
        end
      end
    end else begin
      flash_cnt = '0;
      red_q     = 1'b0;
      green_q   = 1'b0;
    end
  endfunction

  // Work out the result of one accepted input transaction
  function automatic led_result_t predict_item(input cwbc_func_e f, input logic [3:0] ch,
                                               input logic cal);
    led_result_t r;
    int          shown;
    if (f == FUNC_FEED) begin
      // Feeds outside the bank are dropped; nothing but the counter moves
      if (ch < NCH) lost_cnt[ch] = '0;
      shown = first_error();
    end else begin
      if (cal) lost_cnt[0] = '0;
      for (int i = 0; i < NCH; i++) begin
        if (lost_cnt[i] <= timeout_limit(i)) begin
          lost_cnt[i] = lost_cnt[i] + 1'b1;
          err_bits[i] = 1'b0;
        end else begin
          err_bits[i] = 1'b1;
        end
      end
      shown = first_error();
      advance_blink((shown < NCH) ? blink_pattern(shown) : blink_pat_t'{1'b1, 6, 6, 0});
    end
    r.red    = red_q;
    r.green  = green_q;
    r.errors = ERR_OUT_W'(err_bits);
    r.shown  = SHOWN_OUT_W'(shown);
    return r;
  endfunction

  // Offer one item at a falling edge, hold it until the block takes it
  task automatic send_item(input cwbc_func_e f, input logic [3:0] ch, input logic cal);
    led_result_t exp_r;
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.channel    <= ch;
    in_ch.calibrated <= cal;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    exp_r = predict_item(f, ch, cal);
    expected_leds.push_back(exp_r);
    items_sent++;
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_leds.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write ticks_per_second while the block is idle
  task automatic set_tick_rate(input logic [TPS_W-1:0] rate);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tick_rate    = rate;
  endtask

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // Receiver: stall at random, or hold off entirely while the counter runs
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every accepted result transaction against the oldest prediction
  always @(posedge clk_i) begin
    led_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_leds.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, got red %0b green %0b mask %h shown %0d",
                 $time, out_ch.red_led, out_ch.green_led, out_ch.error_mask, out_ch.shown_error);
      end else begin
        want = expected_leds.pop_front();
        check_field("red_led", 32'(want.red), 32'(out_ch.red_led));
        check_field("green_led", 32'(want.green), 32'(out_ch.green_led));
        check_field("error_mask", 32'(want.errors), 32'(out_ch.error_mask));
        check_field("shown_error", 32'(want.shown), 32'(out_ch.shown_error));
        results_checked++;
      end
    end
  end

  // Right after reset every channel is timed out and the calibration pattern shows
  task automatic test_power_up_errors();
    send_item(FUNC_TICK, 4'd0, 1'b0);
    send_item(FUNC_TICK, 4'd15, 1'b1);
    send_item(FUNC_TICK, 4'd5, 1'b0);
  endtask

  // Feeds of the end channels and of channels past the bank; tick ignores its channel field
  task automatic test_feed_handling();
    send_item(FUNC_FEED, 4'd0, 1'b1);
    send_item(FUNC_FEED, 4'd10, 1'b0);
    send_item(FUNC_FEED, 4'd11, 1'b0);
    send_item(FUNC_FEED, 4'd15, 1'b1);
    send_item(FUNC_TICK, 4'd10, 1'b0);
    send_item(FUNC_TICK, 4'd0, 1'b1);
    send_item(FUNC_FEED, 4'd10, 1'b1);
  endtask

  // Slowest tick rate: the steady-red zero-window pattern over several seconds
  task automatic test_zero_window();
    set_tick_rate(10'd1);
    repeat (6) send_item(FUNC_TICK, 4'($urandom_range(15)), 1'b1);
  endtask

  // Keep every channel ahead of the target fed so that the target's pattern shows
  task automatic run_watch_scheme(input int target, input int n_items);
    int         since_fed [NCH];
    int         feed_due  [NCH];
    int         sent;
    int         roll;
    logic [3:0] chan;
    sent = 0;
    for (int c = 0; c < NCH; c++) begin
      since_fed[c] = 0;
      feed_due[c]  = 0;
    end
    for (int c = 1; c < target; c++) begin
      send_item(FUNC_FEED, 4'(c), 1'($urandom_range(1)));
      feed_due[c] = $urandom_range(timeout_limit(c) / 4, timeout_limit(c) - 5);
      sent++;
    end
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        // Noise: anything but a feed of the target channel
        chan = 4'($urandom_range(15));
        if (chan == target) chan = 4'd15;
        send_item(cwbc_func_e'(1'($urandom_range(1))), chan, 1'($urandom_range(1)));
        sent++;
      end else if (roll < 13) begin
        // Broken sequence: a tick that misses the calibration feed
        send_item(FUNC_TICK, 4'($urandom_range(15)), 1'b0);
        sent++;
      end else begin
        for (int c = 1; c < target; c++) begin
          if (since_fed[c] >= feed_due[c]) begin
            send_item(FUNC_FEED, 4'(c), 1'($urandom_range(1)));
            since_fed[c] = 0;
            feed_due[c]  = $urandom_range(timeout_limit(c) / 4, timeout_limit(c) - 5);
            sent++;
          end
        end
        send_item(FUNC_TICK, 4'($urandom_range(15)), 1'(target > 0));
        for (int c = 1; c < target; c++) since_fed[c]++;
        sent++;
      end
    end
  endtask

  // Walk the target up the priority chain; untouched channels are still timed out
  task automatic test_channel_patterns();
    logic [TPS_W-1:0] rate;
    for (int target = 0; target <= NCH; target++) begin
      case (target % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 73;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 73;
        end
        default: begin
          send_idle_pct  = 38;
          recv_stall_pct = 38;
        end
      endcase
      case (target)
        0:       rate = 10'd1000;
        1:       rate = 10'd0;
        NCH - 1: rate = 10'd1023;
        NCH:     rate = 10'($urandom_range(1, 1000));
        default: rate = 10'($urandom_range(1, 4));
      endcase
      set_tick_rate(rate);
      run_watch_scheme(target, 52);
    end
  endtask

  // Hold the receiver off long enough that the block fills and stalls its input
  task automatic test_output_backpressure();
    set_tick_rate(10'($urandom_range(1, 6)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 400;
    repeat (12) send_item(FUNC_TICK, 4'($urandom_range(15)), 1'b1);
    drain_results();
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_TICK;
    in_ch.channel    = '0;
    in_ch.calibrated = 1'b0;
    reset_model();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_power_up_errors();
    test_feed_handling();
    test_zero_window();
    test_channel_patterns();
    test_output_backpressure();

    drain_results();
    repeat (150) @(negedge clk_i);

    $display("Summary: %0d transactions sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, error_count);
    $display("Covered every channel pattern and healthy, tick rates 0 to 1023, four idle mixes");
    if (error_count == 0 && expected_leds.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #4_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
